// ===== design/rca_pkg.sv =====
`default_nettype none

package rca_pkg;

  localparam int unsigned SecondMax = 59;
  localparam int unsigned MinuteMax = 59;
  localparam int unsigned HourMax   = 11;
  localparam int unsigned MonthMax  = 11;
  localparam int unsigned YearMax   = 999;
  localparam int unsigned LeapFeb   = 29;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_ACK   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic {
    REG_ALARM_HOUR = 1'b0,
    REG_ALARM_PM   = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [5:0] second_now;
    logic [5:0] minute_now;
    logic [3:0] hour_shown;
    logic       pm_now;
    logic [4:0] day_now;
    logic [3:0] month_now;
    logic [9:0] year_now;
    logic       alarm_active;
  } result_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    begin
      case (month)
        4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
        4'd1: len = leap ? 5'(LeapFeb) : 5'd28;
        4'd3, 4'd5, 4'd8, 4'd10: len = 5'd30;
        default: len = 5'd31;
      endcase
      return len;
    end
  endfunction

endpackage

`default_nettype wire

// ===== design/rtc_calendar_alarm_core.sv =====
// 12-hour clock and calendar with a set-hour alarm. Each request is a one-second tick,
// a load of time and date (out-of-range fields saturate, day to the month length),
// an alarm acknowledge or a no-op; every request returns one result holding the time,
// date and alarm flag after it. The carry chain and load saturation sit between the
// state registers and a result register backed by a one-entry skid register, so a
// request is accepted every cycle while the skid entry is free.
// Alarm registers are written through the cfg port (index 0 hour 1..12, index 1 PM).
`default_nettype none

module rtc_calendar_alarm_core
  import rca_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_index,
  input  wire logic [3:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] operation,
  input  wire logic [5:0] set_second,
  input  wire logic [5:0] set_minute,
  input  wire logic [3:0] set_hour,
  input  wire logic       set_pm,
  input  wire logic [4:0] set_day,
  input  wire logic [3:0] set_month,
  input  wire logic [9:0] set_year,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [5:0]      second_now,
  output logic [5:0]      minute_now,
  output logic [3:0]      hour_shown,
  output logic            pm_now,
  output logic [4:0]      day_now,
  output logic [3:0]      month_now,
  output logic [9:0]      year_now,
  output logic            alarm_active
);

  logic [3:0] alarm_hour;
  logic       alarm_pm;

  logic [5:0] seconds, seconds_next;
  logic [5:0] minutes, minutes_next;
  logic [3:0] hours, hours_next;
  logic       afternoon, afternoon_next;
  logic [4:0] day_of_month, day_of_month_next;
  logic [3:0] month_index, month_index_next;
  logic [9:0] year_offset, year_offset_next;
  logic       alarm_flag, alarm_flag_next;

  result_t out_reg, skid_reg, result;
  logic    skid_valid;
  logic    accept, out_take;

  logic [3:0] ld_month;
  logic [9:0] ld_year;
  logic [4:0] ld_len, ld_day, cur_len;
  logic [3:0] shown_next;
  op_t        op;

  assign op       = op_t'(operation);
  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  assign ld_month = (set_month > 4'(MonthMax)) ? 4'(MonthMax) : set_month;
  assign ld_year  = (set_year > 10'(YearMax)) ? 10'(YearMax) : set_year;
  assign ld_len   = month_len(ld_month, ld_year[1:0] == 2'd0);
  assign cur_len  = month_len(month_index, year_offset[1:0] == 2'd0);

  always_comb begin
    seconds_next      = seconds;
    minutes_next      = minutes;
    hours_next        = hours;
    afternoon_next    = afternoon;
    day_of_month_next = day_of_month;
    month_index_next  = month_index;
    year_offset_next  = year_offset;
    alarm_flag_next   = alarm_flag;
    ld_day            = (set_day == 5'd0) ? 5'd1 : set_day;
    if (ld_day > ld_len) begin
      ld_day = ld_len;
    end
    case (op)
      OP_TICK: begin
        if (seconds < 6'(SecondMax)) begin
          seconds_next = seconds + 6'd1;
        end else begin
          seconds_next = 6'd0;
          if (minutes < 6'(MinuteMax)) begin
            minutes_next = minutes + 6'd1;
          end else begin
            minutes_next = 6'd0;
            if (hours < 4'(HourMax)) begin
              hours_next = hours + 4'd1;
            end else begin
              hours_next = 4'd0;
              afternoon_next = !afternoon;
              if (afternoon) begin
                if (day_of_month < cur_len) begin
                  day_of_month_next = day_of_month + 5'd1;
                end else begin
                  day_of_month_next = 5'd1;
                  if (month_index < 4'(MonthMax)) begin
                    month_index_next = month_index + 4'd1;
                  end else begin
                    month_index_next = 4'd0;
                    year_offset_next = (year_offset >= 10'(YearMax)) ? 10'd0
                                                                     : year_offset + 10'd1;
                  end
                end
              end
            end
          end
        end
      end
      OP_LOAD: begin
        seconds_next      = (set_second > 6'(SecondMax)) ? 6'(SecondMax) : set_second;
        minutes_next      = (set_minute > 6'(MinuteMax)) ? 6'(MinuteMax) : set_minute;
        hours_next        = (set_hour > 4'(HourMax)) ? 4'(HourMax) : set_hour;
        afternoon_next    = set_pm;
        month_index_next  = ld_month;
        year_offset_next  = ld_year;
        day_of_month_next = ld_day;
      end
      OP_ACK: begin
        alarm_flag_next = 1'b0;
      end
      default: begin
      end
    endcase
    shown_next = (hours_next == 4'd0) ? 4'd12 : hours_next;
    if ((op == OP_TICK || op == OP_LOAD) && minutes_next == 6'd0 &&
        shown_next == alarm_hour && afternoon_next == alarm_pm) begin
      alarm_flag_next = 1'b1;
    end
    result.second_now   = seconds_next;
    result.minute_now   = minutes_next;
    result.hour_shown   = shown_next;
    result.pm_now       = afternoon_next;
    result.day_now      = day_of_month_next;
    result.month_now    = month_index_next + 4'd1;
    result.year_now     = year_offset_next;
    result.alarm_active = alarm_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alarm_hour <= 4'd1;
      alarm_pm   <= 1'b0;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_ALARM_HOUR: alarm_hour <= cfg_data;
        REG_ALARM_PM:   alarm_pm   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seconds      <= 6'd0;
      minutes      <= 6'd0;
      hours        <= 4'd0;
      afternoon    <= 1'b0;
      day_of_month <= 5'd1;
      month_index  <= 4'd0;
      year_offset  <= 10'd0;
      alarm_flag   <= 1'b0;
    end else if (accept) begin
      seconds      <= seconds_next;
      minutes      <= minutes_next;
      hours        <= hours_next;
      afternoon    <= afternoon_next;
      day_of_month <= day_of_month_next;
      month_index  <= month_index_next;
      year_offset  <= year_offset_next;
      alarm_flag   <= alarm_flag_next;
    end
  end

  // hold results in order: output register first, skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (accept) begin
      if (!out_valid || out_take) begin
        out_reg   <= result;
        out_valid <= 1'b1;
      end else begin
        skid_reg   <= result;
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      if (skid_valid) begin
        out_reg    <= skid_reg;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  assign second_now   = out_reg.second_now;
  assign minute_now   = out_reg.minute_now;
  assign hour_shown   = out_reg.hour_shown;
  assign pm_now       = out_reg.pm_now;
  assign day_now      = out_reg.day_now;
  assign month_now    = out_reg.month_now;
  assign year_now     = out_reg.year_now;
  assign alarm_active = out_reg.alarm_active;

endmodule

`default_nettype wire

// ===== tb/rtc_calendar_alarm_checker.sv =====
`timescale 1ns / 100ps

module rtc_calendar_alarm_checker
  import rca_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_write,
  input  wire logic       cfg_index,
  input  wire logic [3:0] cfg_data,
  input  wire logic       in_valid,
  input  wire logic       in_stall,
  input  wire logic [1:0] operation,
  input  wire logic [5:0] set_second,
  input  wire logic [5:0] set_minute,
  input  wire logic [3:0] set_hour,
  input  wire logic       set_pm,
  input  wire logic [4:0] set_day,
  input  wire logic [3:0] set_month,
  input  wire logic [9:0] set_year,
  input  wire logic       out_valid,
  input  wire logic       out_stall,
  input  wire logic [5:0] second_now,
  input  wire logic [5:0] minute_now,
  input  wire logic [3:0] hour_shown,
  input  wire logic       pm_now,
  input  wire logic [4:0] day_now,
  input  wire logic [3:0] month_now,
  input  wire logic [9:0] year_now,
  input  wire logic       alarm_active,
  output int              errors,
  output int              pending
);

  bit [5:0] sec_r;
  bit [5:0] min_r;
  bit [3:0] hour_r;
  bit       pm_r;
  bit [4:0] day_r;
  bit [3:0] mon_r;
  bit [9:0] year_r;
  bit       alarm_r;
  bit [3:0] alarm_hour_r;
  bit       alarm_pm_r;

  result_t expected_readings[$];

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  function automatic bit [4:0] days_in_month(bit [3:0] mon, bit [9:0] year);
    case (mon)
      4'd1: return (year % 4 == 0) ? 5'(LeapFeb) : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10: return 5'd30;
      default: return 5'd31;
    endcase
  endfunction

  task automatic advance_second();
    if (sec_r < SecondMax) begin
      sec_r = sec_r + 1'b1;
    end else begin
      sec_r = '0;
      if (min_r < MinuteMax) begin
        min_r = min_r + 1'b1;
      end else begin
        min_r = '0;
        if (hour_r < HourMax) begin
          hour_r = hour_r + 1'b1;
        end else begin
          hour_r = '0;
          pm_r = ~pm_r;
          // PM to AM rolls the calendar
          if (!pm_r) begin
            if (day_r < days_in_month(mon_r, year_r)) begin
              day_r = day_r + 1'b1;
            end else begin
              day_r = 5'd1;
              if (mon_r < MonthMax) begin
                mon_r = mon_r + 1'b1;
              end else begin
                mon_r = '0;
                year_r = (year_r >= YearMax) ? '0 : year_r + 1'b1;
              end
            end
          end
        end
      end
    end
  endtask

  task automatic load_clock(bit [5:0] s, bit [5:0] m, bit [3:0] h, bit p, bit [4:0] d,
                            bit [3:0] mo, bit [9:0] y);
    bit [4:0] len;
    sec_r = (s > SecondMax) ? 6'(SecondMax) : s;
    min_r = (m > MinuteMax) ? 6'(MinuteMax) : m;
    hour_r = (h > HourMax) ? 4'(HourMax) : h;
    pm_r = p;
    mon_r = (mo > MonthMax) ? 4'(MonthMax) : mo;
    year_r = (y > YearMax) ? 10'(YearMax) : y;
    len = days_in_month(mon_r, year_r);
    day_r = (d == 0) ? 5'd1 : ((d > len) ? len : d);
  endtask

  task automatic check_alarm();
    bit [3:0] shown;
    shown = (hour_r == 0) ? 4'd12 : hour_r;
    if (min_r == 0 && shown == alarm_hour_r && pm_r == alarm_pm_r) alarm_r = 1'b1;
  endtask

  function automatic result_t current_reading();
    result_t r;
    r.second_now = sec_r;
    r.minute_now = min_r;
    r.hour_shown = (hour_r == 0) ? 4'd12 : hour_r;
    r.pm_now = pm_r;
    r.day_now = day_r;
    r.month_now = mon_r + 1'b1;
    r.year_now = year_r;
    r.alarm_active = alarm_r;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    result_t want;
    if (rst) begin
      sec_r = '0;
      min_r = '0;
      hour_r = '0;
      pm_r = 1'b0;
      day_r = 5'd1;
      mon_r = '0;
      year_r = '0;
      alarm_r = 1'b0;
      alarm_hour_r = 4'd1;
      alarm_pm_r = 1'b0;
      expected_readings.delete();
    end else begin
      if (cfg_write) begin
        if (reg_index_t'(cfg_index) == REG_ALARM_HOUR) alarm_hour_r = cfg_data;
        else alarm_pm_r = cfg_data[0];
      end
      if (out_valid && !out_stall) begin
        if (expected_readings.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = expected_readings.pop_front();
          check_field("second_now", second_now, want.second_now);
          check_field("minute_now", minute_now, want.minute_now);
          check_field("hour_shown", hour_shown, want.hour_shown);
          check_field("pm_now", pm_now, want.pm_now);
          check_field("day_now", day_now, want.day_now);
          check_field("month_now", month_now, want.month_now);
          check_field("year_now", year_now, want.year_now);
          check_field("alarm_active", alarm_active, want.alarm_active);
        end
      end
      if (in_valid && !in_stall) begin
        case (op_t'(operation))
          OP_TICK: begin
            advance_second();
            check_alarm();
          end
          OP_LOAD: begin
            load_clock(set_second, set_minute, set_hour, set_pm, set_day, set_month, set_year);
            check_alarm();
          end
          OP_ACK: alarm_r = 1'b0;
          default: ;
        endcase
        expected_readings.push_back(current_reading());
      end
    end
    pending <= expected_readings.size();
  end

endmodule

// ===== tb/tb_rtc_calendar_alarm_core.sv =====
`timescale 1ns / 100ps

module tb_rtc_calendar_alarm_core;
  import rca_pkg::*;

  localparam int CycleLimit = 200000;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic       cfg_index;
  logic [3:0] cfg_data;
  logic       in_valid;
  logic       in_stall;
  logic [1:0] operation;
  logic [5:0] set_second;
  logic [5:0] set_minute;
  logic [3:0] set_hour;
  logic       set_pm;
  logic [4:0] set_day;
  logic [3:0] set_month;
  logic [9:0] set_year;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [5:0] second_now;
  logic [5:0] minute_now;
  logic [3:0] hour_shown;
  logic       pm_now;
  logic [4:0] day_now;
  logic [3:0] month_now;
  logic [9:0] year_now;
  logic       alarm_active;

  int       errors;
  int       pending;
  int       cycles = 0;
  int       stall_hold = 0;
  bit       tx_steady = 1'b0;
  bit       rx_steady = 1'b0;
  bit [3:0] alarm_hour_set = 4'd1;
  bit       alarm_pm_set = 1'b0;

  bit [3:0] hour_plan [9] = '{4'd1, 4'd12, 4'd0, 4'd15, 4'd6, 4'd11, 4'd13, 4'd7, 4'd3};
  bit       pm_plan [9] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};

  rtc_calendar_alarm_core dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .set_second(set_second), .set_minute(set_minute),
    .set_hour(set_hour), .set_pm(set_pm), .set_day(set_day), .set_month(set_month),
    .set_year(set_year),
    .out_valid(out_valid), .out_stall(out_stall),
    .second_now(second_now), .minute_now(minute_now), .hour_shown(hour_shown),
    .pm_now(pm_now), .day_now(day_now), .month_now(month_now), .year_now(year_now),
    .alarm_active(alarm_active)
  );

  rtc_calendar_alarm_checker chk (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .set_second(set_second), .set_minute(set_minute),
    .set_hour(set_hour), .set_pm(set_pm), .set_day(set_day), .set_month(set_month),
    .set_year(set_year),
    .out_valid(out_valid), .out_stall(out_stall),
    .second_now(second_now), .minute_now(minute_now), .hour_shown(hour_shown),
    .pm_now(pm_now), .day_now(day_now), .month_now(month_now), .year_now(year_now),
    .alarm_active(alarm_active),
    .errors(errors), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("rtc_calendar_alarm_core regression: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst || rx_steady) begin
      out_stall <= 1'b0;
      stall_hold = 0;
    end else if (stall_hold != 0) begin
      stall_hold--;
    end else begin
      out_stall <= ($urandom_range(0, 2) == 0);
      stall_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
    end
  end

  task automatic send_request(op_t op, bit [5:0] s, bit [5:0] m, bit [3:0] h, bit p,
                              bit [4:0] d, bit [3:0] mo, bit [9:0] y);
    int gap;
    int pick;
    in_valid <= 1'b1;
    operation <= op;
    set_second <= s;
    set_minute <= m;
    set_hour <= h;
    set_pm <= p;
    set_day <= d;
    set_month <= mo;
    set_year <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pick = $urandom_range(0, 99);
    if (tx_steady || pick < 55) gap = 0;
    else if (pick < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic write_alarm(bit [3:0] hour, bit pm);
    cfg_write <= 1'b1;
    cfg_index <= REG_ALARM_HOUR;
    cfg_data <= hour;
    @(posedge clk);
    cfg_index <= REG_ALARM_PM;
    cfg_data <= {3'b000, pm};
    @(posedge clk);
    cfg_write <= 1'b0;
    alarm_hour_set = hour;
    alarm_pm_set = pm;
  endtask

  task automatic send_random();
    int pick;
    bit [3:0] alarm_hr;
    bit [5:0] s;
    bit [5:0] m;
    bit [3:0] h;
    bit p;
    bit [4:0] d;
    bit [3:0] mo;
    bit [9:0] y;
    pick = $urandom_range(0, 99);
    s = 6'($urandom);
    m = 6'($urandom);
    h = 4'($urandom);
    p = 1'($urandom);
    d = 5'($urandom);
    mo = 4'($urandom);
    y = 10'($urandom);
    alarm_hr = (alarm_hour_set == 4'd12) ? 4'd0 : alarm_hour_set;
    if (pick < 58) begin
      send_request(OP_TICK, s, m, h, p, d, mo, y);
    end else if (pick < 66) begin
      send_request(OP_LOAD, s, m, h, p, d, mo, y);
    end else if (pick < 76) begin
      // land just short of a carry so the ticks that follow roll it
      s = 6'($urandom_range(50, 59));
      m = 6'd59;
      h = $urandom_range(0, 1) ? 4'd11 : 4'($urandom_range(0, 11));
      d = 5'($urandom_range(27, 31));
      mo = 4'($urandom_range(0, 11));
      y = ($urandom_range(0, 7) == 0) ? 10'd999 : 10'($urandom_range(0, 999));
      send_request(OP_LOAD, s, m, h, p, d, mo, y);
    end else if (pick < 82) begin
      p = alarm_pm_set;
      if ($urandom_range(0, 1)) begin
        m = 6'd0;
        h = alarm_hr;
      end else begin
        s = 6'($urandom_range(55, 59));
        m = 6'd59;
        h = (alarm_hr == 0) ? 4'd11 : alarm_hr - 1'b1;
        if (alarm_hr == 0) p = ~alarm_pm_set;
      end
      send_request(OP_LOAD, s, m, h, p, d, mo, y);
    end else if (pick < 94) begin
      send_request(OP_ACK, s, m, h, p, d, mo, y);
    end else begin
      send_request(OP_NONE, s, m, h, p, d, mo, y);
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_ALARM_HOUR;
    cfg_data = '0;
    in_valid = 1'b0;
    operation = OP_TICK;
    set_second = '0;
    set_minute = '0;
    set_hour = '0;
    set_pm = 1'b0;
    set_day = '0;
    set_month = '0;
    set_year = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_alarm(4'd12, 1'b0);

    send_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_ACK, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_ACK, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_NONE, 6'h3f, 6'h3f, 4'hf, 1, 5'h1f, 4'hf, 10'h3ff);
    send_request(OP_LOAD, 59, 59, 11, 1, 31, 11, 999);
    send_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_ACK, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_LOAD, 6'h3f, 6'h3f, 4'hf, 1, 5'h1f, 4'hf, 10'h3ff);
    send_request(OP_LOAD, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_LOAD, 0, 0, 0, 0, 31, 1, 4);
    send_request(OP_LOAD, 0, 0, 0, 0, 30, 1, 3);
    send_request(OP_LOAD, 59, 59, 11, 1, 28, 1, 3);
    send_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_LOAD, 59, 59, 11, 1, 28, 1, 4);
    send_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_LOAD, 59, 59, 11, 0, 15, 5, 500);
    send_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_LOAD, 59, 59, 11, 1, 30, 3, 7);
    send_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_LOAD, 59, 59, 5, 0, 10, 6, 42);
    send_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_LOAD, 59, 59, 11, 1, 31, 0, 998);
    send_request(OP_TICK, 0, 0, 0, 0, 0, 0, 0);
    send_request(OP_NONE, 0, 0, 0, 0, 0, 0, 0);
    wait_for_results();

    for (int ph = 0; ph < 9; ph++) begin
      write_alarm(hour_plan[ph], pm_plan[ph]);
      tx_steady = (ph % 3 == 1);
      rx_steady = (ph % 3 == 2);
      repeat (92) send_random();
      wait_for_results();
    end

    repeat (4) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("rtc_calendar_alarm_core regression: pass");
    end else begin
      $display("rtc_calendar_alarm_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/rca_pkg.sv
design/rtc_calendar_alarm_core.sv
tb/rtc_calendar_alarm_checker.sv
tb/tb_rtc_calendar_alarm_core.sv
